### rtl/core/icm_pkg.sv
// Shared types, constants and codes for the interval coverage merger.
package icm_pkg;

    localparam int unsigned DATA_W            = 32;
    localparam int unsigned MAX_INTERVALS_DEF = 16;
    localparam int unsigned CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] seg_start;
        logic [DATA_W-1:0] seg_end;
    } seg_t;

    typedef struct packed {
        logic fully_covered;
        logic table_overflow;
    } res_t;

    typedef struct packed {
        logic [DATA_W-1:0] ent_start;
        logic [DATA_W-1:0] ent_end;
    } entry_t;

    typedef struct packed {
        logic ent_lt_seg_start;
        logic seg_end_ge_ent;
        logic ent_end_ge_seg;
        logic ent_end_gt_seg_end;
        logic ent_eq;
        logic ent_lt_pair;
    } cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DUP,
        ST_COPY
    } state_t;

endpackage

### rtl/core/interval_coverage_merger.sv
// Top level of the interval coverage merger: configuration registers and unit wiring.
//
// Each transaction adds one segment [seg_start, seg_end) to a sorted table of up to
// MAX_INTERVALS disjoint intervals, merging every stored interval it overlaps or touches.
// busy stays high while a transaction is in progress; done pulses for one cycle with the
// result, and the receiver cannot stall it. The next transaction can be accepted while
// done is high. A transaction's length is set by the single read port of the table: a
// forward scan, a backward scan, a duplicate check and a compacting copy into the other
// bank each read one entry per cycle through one shared compare unit, so the length
// grows with the number of stored intervals.
// The table needs no clearing after reset. Write range_start and range_end only while idle.
module interval_coverage_merger #(
    parameter int unsigned MAX_INTERVALS = icm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  icm_pkg::seg_t                   seg,
    output logic                            busy,
    output logic                            done,
    output icm_pkg::res_t                   result,
    input  logic                            cfg_we,
    input  logic [icm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [icm_pkg::DATA_W-1:0]      cfg_data
);

    localparam int unsigned IW = $clog2(MAX_INTERVALS);

    logic [icm_pkg::DATA_W-1:0] range_start_reg;
    logic [icm_pkg::DATA_W-1:0] range_end_reg;

    logic                       mem_we;
    logic [IW:0]                mem_waddr;
    logic [IW:0]                mem_raddr;
    icm_pkg::entry_t            mem_wdata;
    icm_pkg::entry_t            mem_rdata;
    icm_pkg::cmp_t              cmp;
    logic [icm_pkg::DATA_W-1:0] cur_start;
    logic [icm_pkg::DATA_W-1:0] cur_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= '0;
            range_end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                icm_pkg::REG_RANGE_START: range_start_reg <= cfg_data;
                icm_pkg::REG_RANGE_END:   range_end_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    icm_table #(
        .AW (IW + 1)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    icm_cmp u_cmp (
        .ent       (mem_rdata),
        .cur_start (cur_start),
        .cur_end   (cur_end),
        .flags     (cmp)
    );

    icm_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .seg         (seg),
        .range_start (range_start_reg),
        .range_end   (range_end_reg),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .cur_start   (cur_start),
        .cur_end     (cur_end),
        .cmp         (cmp)
    );

endmodule

### rtl/core/icm_table.sv
// Two-bank interval table memory with one write port and one registered read port.
module icm_table #(
    parameter int unsigned AW = 5
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  icm_pkg::entry_t    wdata,
    input  logic [AW-1:0]      raddr,
    output icm_pkg::entry_t    rdata
);

    icm_pkg::entry_t mem [2**AW];
    icm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### rtl/core/icm_cmp.sv
// Shared compare unit: checks one stored entry against the working interval.
module icm_cmp (
    input  icm_pkg::entry_t              ent,
    input  logic [icm_pkg::DATA_W-1:0]   cur_start,
    input  logic [icm_pkg::DATA_W-1:0]   cur_end,
    output icm_pkg::cmp_t                flags
);

    always_comb
    begin
        flags.ent_lt_seg_start   = ent.ent_start < cur_start;
        flags.seg_end_ge_ent     = cur_end >= ent.ent_start;
        flags.ent_end_ge_seg     = ent.ent_end >= cur_start;
        flags.ent_end_gt_seg_end = ent.ent_end > cur_end;
        flags.ent_eq             = (ent.ent_start == cur_start) && (ent.ent_end == cur_end);
        flags.ent_lt_pair        = (ent.ent_start < cur_start) ||
                                   ((ent.ent_start == cur_start) && (ent.ent_end < cur_end));
    end

endmodule

### rtl/core/icm_ctrl.sv
// Sequencer and working registers: scan, absorb, duplicate check and compacting copy.
module icm_ctrl #(
    parameter int unsigned MAX_INTERVALS = icm_pkg::MAX_INTERVALS_DEF,
    localparam int unsigned IW = $clog2(MAX_INTERVALS),
    localparam int unsigned CW = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  icm_pkg::seg_t                seg,
    input  logic [icm_pkg::DATA_W-1:0]   range_start,
    input  logic [icm_pkg::DATA_W-1:0]   range_end,
    output logic                         busy,
    output logic                         done,
    output icm_pkg::res_t                result,
    output logic                         mem_we,
    output logic [IW:0]                  mem_waddr,
    output icm_pkg::entry_t              mem_wdata,
    output logic [IW:0]                  mem_raddr,
    input  icm_pkg::entry_t              mem_rdata,
    output logic [icm_pkg::DATA_W-1:0]   cur_start,
    output logic [icm_pkg::DATA_W-1:0]   cur_end,
    input  icm_pkg::cmp_t                cmp
);

    icm_pkg::state_t state_reg, state_next;

    logic [icm_pkg::DATA_W-1:0] s_reg, s_next;
    logic [icm_pkg::DATA_W-1:0] e_reg, e_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic          vld_reg, vld_next;
    logic          found_reg, found_next;
    logic          dup_reg, dup_next;
    logic          ins_reg, ins_next;
    logic          bank_reg, bank_next;
    logic          done_reg, done_next;
    icm_pkg::res_t res_reg, res_next;

    logic          issue;
    logic          outside;
    logic          covered;
    logic [CW-1:0] lo_v;
    logic [CW-1:0] rd_idx;

    assign issue   = idx_reg < n_reg;
    assign outside = (ridx_reg < lo_reg) || (ridx_reg >= hi_reg);
    assign covered = (s_reg == range_start) && (e_reg == range_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icm_pkg::ST_IDLE;
            n_reg     <= '0;
            bank_reg  <= 1'b0;
            vld_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            bank_reg  <= bank_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        e_reg     <= e_next;
        idx_reg   <= idx_next;
        ridx_reg  <= ridx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        wptr_reg  <= wptr_next;
        found_reg <= found_next;
        dup_reg   <= dup_next;
        ins_reg   <= ins_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        ridx_next  = ridx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        wptr_next  = wptr_reg;
        vld_next   = 1'b0;
        found_next = found_reg;
        dup_next   = dup_reg;
        ins_next   = ins_reg;
        bank_next  = bank_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rd_idx     = idx_reg;
        lo_v       = lo_reg;
        mem_we     = 1'b0;
        mem_wdata  = '{ent_start: s_reg, ent_end: e_reg};

        unique case (state_reg)
            icm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    s_next     = seg.seg_start;
                    e_next     = seg.seg_end;
                    idx_next   = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    state_next = icm_pkg::ST_FWD;
                end
            end

            icm_pkg::ST_FWD:
            begin
                vld_next  = issue;
                ridx_next = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (vld_reg)
                begin
                    if (found_reg || !cmp.ent_lt_seg_start)
                    begin
                        lo_v = found_reg ? lo_reg : ridx_reg;
                        lo_next    = lo_v;
                        found_next = 1'b1;
                        if (cmp.seg_end_ge_ent)
                        begin
                            if (cmp.ent_end_gt_seg_end)
                            begin
                                e_next = mem_rdata.ent_end;
                            end
                        end
                        else
                        begin
                            hi_next    = ridx_reg;
                            idx_next   = lo_v;
                            vld_next   = 1'b0;
                            state_next = icm_pkg::ST_BWD;
                        end
                    end
                end
                else if (!issue)
                begin
                    lo_v       = found_reg ? lo_reg : n_reg;
                    lo_next    = lo_v;
                    hi_next    = n_reg;
                    idx_next   = lo_v;
                    state_next = icm_pkg::ST_BWD;
                end
            end

            icm_pkg::ST_BWD:
            begin
                rd_idx    = idx_reg - CW'(1);
                vld_next  = idx_reg != '0;
                ridx_next = rd_idx;
                if (idx_reg != '0)
                begin
                    idx_next = rd_idx;
                end
                if (vld_reg)
                begin
                    if (cmp.ent_end_ge_seg)
                    begin
                        if (cmp.ent_end_gt_seg_end)
                        begin
                            e_next = mem_rdata.ent_end;
                        end
                        s_next  = mem_rdata.ent_start;
                        lo_next = ridx_reg;
                    end
                    else
                    begin
                        idx_next   = '0;
                        vld_next   = 1'b0;
                        state_next = icm_pkg::ST_DUP;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = icm_pkg::ST_DUP;
                end
            end

            icm_pkg::ST_DUP:
            begin
                vld_next  = issue;
                ridx_next = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (vld_reg)
                begin
                    if (outside && cmp.ent_eq)
                    begin
                        dup_next = 1'b1;
                    end
                end
                else if (!issue)
                begin
                    if (hi_reg == lo_reg && !dup_reg && n_reg == CW'(MAX_INTERVALS))
                    begin
                        done_next  = 1'b1;
                        res_next   = '{fully_covered: 1'b0, table_overflow: 1'b1};
                        state_next = icm_pkg::ST_IDLE;
                    end
                    else if (hi_reg == lo_reg && dup_reg)
                    begin
                        done_next  = 1'b1;
                        res_next   = '{fully_covered: covered, table_overflow: 1'b0};
                        state_next = icm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        wptr_next  = '0;
                        ins_next   = 1'b0;
                        state_next = icm_pkg::ST_COPY;
                    end
                end
            end

            icm_pkg::ST_COPY:
            begin
                vld_next  = issue;
                ridx_next = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (vld_reg)
                begin
                    if (outside)
                    begin
                        mem_we    = 1'b1;
                        wptr_next = wptr_reg + CW'(1);
                        if (!ins_reg && !dup_reg && !cmp.ent_lt_pair)
                        begin
                            ins_next  = 1'b1;
                            rd_idx    = ridx_reg;
                            vld_next  = 1'b1;
                            ridx_next = ridx_reg;
                            idx_next  = ridx_reg + CW'(1);
                        end
                        else
                        begin
                            mem_wdata = mem_rdata;
                        end
                    end
                end
                else if (!issue)
                begin
                    mem_we     = !ins_reg && !dup_reg;
                    n_next     = wptr_reg + CW'(mem_we);
                    bank_next  = !bank_reg;
                    done_next  = 1'b1;
                    res_next   = '{fully_covered: covered, table_overflow: 1'b0};
                    state_next = icm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = icm_pkg::ST_IDLE;
            end
        endcase
    end

    assign mem_raddr = {bank_reg, rd_idx[IW-1:0]};
    assign mem_waddr = {!bank_reg, wptr_reg[IW-1:0]};
    assign cur_start = s_reg;
    assign cur_end   = e_reg;
    assign busy      = state_reg != icm_pkg::ST_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == icm_pkg::ST_COPY)
        else $error("table write outside the copy pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_overflow) |-> (n_reg == CW'(MAX_INTERVALS)))
        else $error("overflow reported with room in the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result.fully_covered || !result.table_overflow)
        else $error("overflow and coverage reported together");

endmodule
